FILE: src/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared constants for the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;
   localparam int MAX_INTERVALS_DEF = 256;
   localparam logic [31:0] HEAP_SIZE_RESET = 32'd16777216;
   localparam logic [7:0] SIZE_ALIGN_MASK = 8'd255;
   localparam logic [4:0] HEAP_ALIGN_MASK = 5'd31;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam int REG_HEAP_SIZE = 0;
endpackage

FILE: src/first_fit_range_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator_top
// First-fit allocator over a heap of offsets, interval table kept sorted.
// ----------------------------------------------------------------------------
// channel | ports   | dir | content
// req     | req_*   | in  | tdata: request_size, free_offset; tuser: operation
// rsp     | rsp_*   | out | tdata: block_offset, allocated_bytes, live_allocations;
//         |         |     | tuser: status
// csr     | csr_*   | in  | APB, heap_size at address 0
// A request scans the table one entry at a time through the registered memory
// port, then the shift moves one entry at a time through a read and a write
// state. The table size bounds both the scan and the shift.
// Reset clears count and byte total, reloads heap size; memory needs no clearing.
// req_tready is low from acceptance until the result beat is taken.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_top
   import ffra_pkg::*;
#(
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] request_size, [63:32] free_offset
   input  logic        req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [31:0] block_offset, [63:32] allocated_bytes,
                                    // [72:64] live_allocations, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SREAD = 3'd1;
   localparam logic [2:0] S_SCHK = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_MREAD = 3'd4;
   localparam logic [2:0] S_MWRITE = 3'd5;
   localparam logic [2:0] S_OUT = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   total_ff, total_in;
   logic [31:0]   heap_ff, heap_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [32:0]   cur_ff, cur_in;
   logic [32:0]   size_ff, size_in;
   logic          op_ff, op_in;
   logic [31:0]   foff_ff, foff_in;
   logic          found_ff, found_in;
   logic [31:0]   fsize_ff, fsize_in;
   logic [1:0]    st_ff, st_in;
   logic [31:0]   boff_ff, boff_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_data, rd_data;
   logic [31:0]   e_start, e_end;
   logic [33:0]   fit_sum;
   logic [32:0]   end_up;
   logic          csr_wr;

   ffra_table #(.DEPTH(MAX_INTERVALS), .AW(AW)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign e_start = rd_data[31:0];
   assign e_end = rd_data[63:32];
   assign fit_sum = {1'b0, cur_ff} + {1'b0, size_ff};
   assign end_up = ({1'b0, e_end} + 33'd255) & ~33'd255;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = heap_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tuser = st_ff;
   assign rsp_tdata = {7'd0, 9'(count_ff), total_ff, boff_ff};

   always_comb begin
      state_in = state_ff; count_in = count_ff; total_in = total_ff;
      heap_in = heap_ff; idx_in = idx_ff; pos_in = pos_ff; cur_in = cur_ff;
      size_in = size_ff; op_in = op_ff; foff_in = foff_ff; found_in = found_ff;
      fsize_in = fsize_ff; st_in = st_ff; boff_in = boff_ff;
      wr_en = 1'b0; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      if (csr_wr && csr_paddr == 2'(REG_HEAP_SIZE)) begin
         heap_in = (csr_pwdata + 32'd31) & ~32'(HEAP_ALIGN_MASK);
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tuser;
               foff_in = req_tdata[63:32];
               size_in = ({1'b0, req_tdata[31:0]} + 33'd255) & ~33'd255;
               cur_in = '0; idx_in = '0; pos_in = count_ff; found_in = 1'b0;
               state_in = S_SREAD;
            end
         end
         S_SREAD: begin
            if (idx_ff == count_ff) state_in = S_DECIDE;
            else state_in = S_SCHK;
         end
         S_SCHK: begin
            state_in = S_SREAD;
            idx_in = idx_ff + 1'b1;
            if (op_ff == OP_ALLOC) begin
               if (fit_sum > {2'b0, e_start}) cur_in = end_up;
               else begin
                  pos_in = idx_ff; state_in = S_DECIDE;
               end
            end else if (e_start == foff_ff) begin
               pos_in = idx_ff; found_in = 1'b1;
               fsize_in = e_end - e_start; state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            boff_in = '0;
            state_in = S_OUT;
            if (op_ff == OP_ALLOC) begin
               if (fit_sum > {2'b0, heap_ff}) st_in = ST_NO_SPACE;
               else if (count_ff >= CW'(MAX_INTERVALS)) st_in = ST_TABLE_FULL;
               else begin
                  st_in = ST_OK; boff_in = cur_ff[31:0];
                  total_in = total_ff + size_ff[31:0];
                  idx_in = count_ff;
                  state_in = S_MREAD;
               end
            end else if (found_ff) begin
               st_in = ST_OK;
               total_in = total_ff - fsize_ff;
               idx_in = pos_ff;
               state_in = S_MREAD;
            end else st_in = ST_NOT_FOUND;
         end
         S_MREAD: begin
            // alloc walks down from count, free walks up from the hole
            if (op_ff == OP_ALLOC) begin
               rd_addr = AW'(idx_ff - 1'b1);
               if (idx_ff == pos_ff) begin
                  wr_en = 1'b1;
                  wr_data = {cur_ff[31:0] + size_ff[31:0], cur_ff[31:0]};
                  count_in = count_ff + 1'b1;
                  state_in = S_OUT;
               end else state_in = S_MWRITE;
            end else begin
               rd_addr = AW'(idx_ff + 1'b1);
               if (idx_ff + 1'b1 >= count_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_OUT;
               end else state_in = S_MWRITE;
            end
         end
         S_MWRITE: begin
            wr_en = 1'b1;
            state_in = S_MREAD;
            idx_in = (op_ff == OP_ALLOC) ? idx_ff - 1'b1 : idx_ff + 1'b1;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         heap_ff <= HEAP_SIZE_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         heap_ff <= heap_in;
      end
      idx_ff <= idx_in; pos_ff <= pos_in; cur_ff <= cur_in; size_ff <= size_in;
      op_ff <= op_in; foff_ff <= foff_in; found_ff <= found_in;
      fsize_ff <= fsize_in; st_ff <= st_in; boff_ff <= boff_in;
   end

`ifndef SYNTH
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_INTERVALS)) else $error("interval count overflow");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |=> $stable(count_ff)) else $error("count moved in idle");
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[31:0] == 32'd0)
      else $error("offset on failed request");
`endif
endmodule

FILE: src/ffra_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_table
// Interval memory: start and end of each interval packed in one word,
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffra_table #(
   parameter int DEPTH = 256,
   parameter int AW = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_data
);
   logic [63:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: bench/tb_first_fit_range_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_range_allocator_top
// Self-checking bench for the first-fit range allocator: a directed table of
// requests, then random allocate/free traffic checked against a behavioral
// model of the interval table, under heap size changes and random stalls.
// ----------------------------------------------------------------------------
module tb_first_fit_range_allocator_top;
   import ffra_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] block_offset;
      logic [31:0] allocated_bytes;
      logic [8:0]  live_allocations;
   } alloc_result_type;

   typedef struct {
      logic        op;
      logic [31:0] size;
      logic [31:0] offset;
      logic        typed;     // expected result typed in below
      logic [1:0]  status;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   first_fit_range_allocator_top u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // model of the block
   logic [31:0]      heap_bytes;
   logic [31:0]      ivl_start [$];
   logic [31:0]      ivl_end [$];
   logic [31:0]      held_bytes;
   alloc_result_type pending_results [$];
   int               fail_count = 0;
   logic             rx_quiet = 1'b0;   // last part: no stalls
   int               rx_hold = 0;       // long receiver hold-off, in cycles

   function automatic alloc_result_type predict_request(logic op, logic [31:0] size_req,
                                                        logic [31:0] off);
      alloc_result_type r;
      logic [63:0] size;
      logic [63:0] cur;
      int pos;
      int idx;
      r = '0;
      if (op == OP_ALLOC) begin
         size = (64'(size_req) + 64'(SIZE_ALIGN_MASK)) & ~64'(SIZE_ALIGN_MASK);
         cur = 0;
         pos = ivl_start.size();
         for (int i = 0; i < ivl_start.size(); i++) begin
            if (cur + size > 64'(ivl_start[i]))
               cur = (64'(ivl_end[i]) + 64'(SIZE_ALIGN_MASK)) & ~64'(SIZE_ALIGN_MASK);
            else begin
               pos = i;
               break;
            end
         end
         if (cur + size > 64'(heap_bytes))
            r.status = ST_NO_SPACE;
         else if (ivl_start.size() >= MAX_INTERVALS_DEF)
            r.status = ST_TABLE_FULL;
         else begin
            r.status = ST_OK;
            ivl_start.insert(pos, cur[31:0]);
            ivl_end.insert(pos, 32'(cur + size));
            held_bytes = held_bytes + size[31:0];
            r.block_offset = cur[31:0];
         end
      end else begin
         idx = -1;
         for (int i = 0; i < ivl_start.size(); i++)
            if (ivl_start[i] == off) begin
               idx = i;
               break;
            end
         if (idx < 0)
            r.status = ST_NOT_FOUND;
         else begin
            r.status = ST_OK;
            held_bytes = held_bytes - (ivl_end[idx] - ivl_start[idx]);
            ivl_start.delete(idx);
            ivl_end.delete(idx);
         end
      end
      r.allocated_bytes = held_bytes;
      r.live_allocations = 9'(ivl_start.size());
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // result side: random stalls, long hold-off, checking
   always @(posedge clock) begin
      alloc_result_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.block_offset = rsp_tdata[31:0];
            got.allocated_bytes = rsp_tdata[63:32];
            got.live_allocations = rsp_tdata[72:64];
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result beat", 32'(rsp_tuser), 32'd0);
            end else begin
               want = pending_results.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               if (got.block_offset !== want.block_offset)
                  report_mismatch("block_offset", got.block_offset, want.block_offset);
               if (got.allocated_bytes !== want.allocated_bytes)
                  report_mismatch("allocated_bytes", got.allocated_bytes,
                                  want.allocated_bytes);
               if (got.live_allocations !== want.live_allocations)
                  report_mismatch("live_allocations", 32'(got.live_allocations),
                                  32'(want.live_allocations));
            end
         end
      end
   end

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (rx_hold > 0) begin
            @(posedge clock) rsp_tready <= 1'b0;
            repeat (rx_hold - 1) @(posedge clock);
            rx_hold = 0;
         end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            @(posedge clock) rsp_tready <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end else
            @(posedge clock) rsp_tready <= 1'b1;
      end
   end

   task automatic write_heap_size(logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 2'(REG_HEAP_SIZE * 4);
      csr_pwdata <= value;
      @(posedge clock) csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      heap_bytes = (value + 32'(HEAP_ALIGN_MASK)) & ~32'(HEAP_ALIGN_MASK);
   endtask

   // called right after an accepting edge; drops the request beat
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one request beat; called right after a rising edge (or at time 0 region)
   task automatic send_request(logic op, logic [31:0] size_req, logic [31:0] off,
                               logic typed, logic [1:0] typed_status);
      alloc_result_type r;
      int gap;
      if (!rx_quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {off, size_req};
      do @(posedge clock); while (!req_tready);
      r = predict_request(op, size_req, off);
      if (typed && r.status !== typed_status)
         report_mismatch("table status", 32'(r.status), 32'(typed_status));
      pending_results.push_back(r);
   endtask

   // random allocate: mostly modest sizes, sometimes huge
   function automatic logic [31:0] random_size();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
         2: return 0;
         default: return $urandom_range(0, 4096);
      endcase
   endfunction

   function automatic logic [31:0] random_free_offset();
      if (ivl_start.size() != 0 && $urandom_range(0, 7) != 0)
         return ivl_start[$urandom_range(0, ivl_start.size() - 1)];
      return $urandom();
   endfunction

   stim_row_type directed [15] = '{
      '{OP_FREE,  32'd0,          32'd0,          1'b1, ST_NOT_FOUND},
      '{OP_ALLOC, 32'd0,          32'd0,          1'b1, ST_OK},
      '{OP_ALLOC, 32'd1,          32'd0,          1'b1, ST_OK},
      '{OP_ALLOC, 32'd256,        32'd0,          1'b1, ST_OK},
      '{OP_ALLOC, 32'd257,        32'd0,          1'b1, ST_OK},
      '{OP_ALLOC, 32'hFFFF_FFFF,  32'd0,          1'b1, ST_NO_SPACE},
      '{OP_ALLOC, 32'hFFFF_FF01,  32'hFFFF_FFFF,  1'b1, ST_NO_SPACE},
      '{OP_FREE,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, ST_NOT_FOUND},
      '{OP_FREE,  32'd0,          32'd256,        1'b1, ST_OK},
      '{OP_ALLOC, 32'd100,        32'd0,          1'b0, ST_OK},
      '{OP_FREE,  32'd0,          32'd0,          1'b1, ST_OK},
      '{OP_FREE,  32'd0,          32'd0,          1'b0, ST_OK},
      '{OP_ALLOC, 32'h00FF_FF00,  32'd0,          1'b0, ST_OK},
      '{OP_ALLOC, 32'h0100_0000,  32'd0,          1'b1, ST_NO_SPACE},
      '{OP_FREE,  32'hAAAA_5555,  32'h5555_AAAA,  1'b1, ST_NOT_FOUND}
   };

   initial begin
      heap_bytes = HEAP_SIZE_RESET;
      held_bytes = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_request(directed[i].op, directed[i].size, directed[i].offset,
                      directed[i].typed, directed[i].status);
      wait_drained();

      // fill the table: table-full case, plus a long receiver hold-off
      write_heap_size(32'hFFFF_FFE0);
      rx_hold = 600;
      while (ivl_start.size() < MAX_INTERVALS_DEF)
         send_request(OP_ALLOC, 32'd0, 32'd0, 1'b0, ST_OK);
      send_request(OP_ALLOC, 32'd1, 32'd0, 1'b1, ST_TABLE_FULL);
      send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_NO_SPACE);
      while (ivl_start.size() > 0)
         send_request(OP_FREE, 32'd0, random_free_offset(), 1'b0, ST_OK);
      wait_drained();   // sender pauses until all results are in

      // random phases, each under its own heap size
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_heap_size(32'hFFFF_FFFF);  // wraps to 0
            1: write_heap_size(32'h0000_4001);
            2: write_heap_size(32'hFFFF_FFE0);
            3: write_heap_size(32'h0001_0000 | 32'($urandom_range(0, 31)));
            4: write_heap_size($urandom());
            default: begin
               write_heap_size(32'h0010_0000);
               rx_quiet = 1'b1;
            end
         endcase
         for (int n = 0; n < 80; n++)
            if ($urandom_range(0, 2) == 0)
               send_request(OP_FREE, $urandom(), random_free_offset(), 1'b0, ST_OK);
            else
               send_request(OP_ALLOC, random_size(), $urandom(), 1'b0, ST_OK);
         wait_drained();
      end

      repeat (1100) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #40ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
